// ===== design/framebuffer_config_best_match_macros.svh =====
// Assertion macros shared by the framebuffer format selector.
`ifndef FRAMEBUFFER_CONFIG_BEST_MATCH_MACROS_SVH
`define FRAMEBUFFER_CONFIG_BEST_MATCH_MACROS_SVH

// Same-cycle implication, checked on every rising clock outside reset.
`define FBCM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Next-cycle implication, checked on every rising clock outside reset.
`define FBCM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// ===== design/fbcm_pkg.sv =====
// Types, register indexes and constants of the framebuffer format selector.
package fbcm_pkg;

   localparam int CSR_DATA_W  = 36;
   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_COLOR   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEPTH   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STENCIL = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACCUM   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_AUX     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLES = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLAGS   = 3'd7;

   // 9-bit two's complement -1: the lane is ignored
   localparam logic [8:0]  LANE_IGNORE = 9'h1FF;
   localparam logic [17:0] COLOR_MAX   = 18'h3FFFF;
   localparam logic [19:0] EXTRA_MAX   = 20'hFFFFF;

   typedef struct packed {
      logic [2:0]  want_flags;
      logic [8:0]  want_samples;
      logic [7:0]  want_aux;
      logic [35:0] want_accum;
      logic [8:0]  want_stencil;
      logic [8:0]  want_depth;
      logic [8:0]  want_alpha;
      logic [26:0] want_color;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      want_flags:   3'd0,
      want_samples: 9'h1FF,
      want_aux:     8'd0,
      want_accum:   36'hFFFFFFFFF,
      want_stencil: 9'h1FF,
      want_depth:   9'h1FF,
      want_alpha:   9'h1FF,
      want_color:   27'h7FFFFFF
   };

   typedef struct packed {
      logic [7:0]  cand_red;
      logic [7:0]  cand_green;
      logic [7:0]  cand_blue;
      logic [7:0]  cand_alpha;
      logic [7:0]  cand_depth;
      logic [7:0]  cand_stencil;
      logic [31:0] cand_accum;
      logic [7:0]  cand_aux;
      logic [7:0]  cand_samples;
      logic [2:0]  cand_flags;
      logic [15:0] cand_tag;
      logic        cand_last;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [15:0] chosen_tag;
   } rsp_type;

   typedef struct packed {
      logic        reject;
      logic [8:0]  missing;
      logic [17:0] color;
      logic [19:0] extra;
   } score_type;

endpackage

// ===== design/fbcm_score.sv =====
// Scoring logic: rejection test and the missing, color and extra scores of one candidate.
module fbcm_score (
   input  fbcm_pkg::cfg_type   cfg,
   input  fbcm_pkg::req_type   cand,
   output fbcm_pkg::score_type score
);
   import fbcm_pkg::*;

   function automatic logic [17:0] sqd(input logic [8:0] w, input logic [7:0] c);
      logic signed [9:0]  d;
      logic signed [19:0] p;
      d = $signed({w[8], w}) - $signed({2'b00, c});
      p = d * d;
      return p[17:0];
   endfunction

   // strictly positive want
   function automatic logic wanted(input logic [8:0] w);
      return !w[8] && (w != 9'd0);
   endfunction

   logic [8:0]  col_w [3];
   logic [7:0]  col_c [3];
   logic [8:0]  ext_w [8];
   logic [7:0]  ext_c [8];
   logic [19:0] color_sum;
   logic [21:0] extra_sum;
   logic [8:0]  aux_short;

   always_comb begin
      col_w[0] = cfg.want_color[8:0];
      col_w[1] = cfg.want_color[17:9];
      col_w[2] = cfg.want_color[26:18];
      col_c[0] = cand.cand_red;
      col_c[1] = cand.cand_green;
      col_c[2] = cand.cand_blue;

      ext_w[0] = cfg.want_alpha;
      ext_w[1] = cfg.want_depth;
      ext_w[2] = cfg.want_stencil;
      ext_w[3] = cfg.want_accum[8:0];
      ext_w[4] = cfg.want_accum[17:9];
      ext_w[5] = cfg.want_accum[26:18];
      ext_w[6] = cfg.want_accum[35:27];
      ext_w[7] = cfg.want_samples;
      ext_c[0] = cand.cand_alpha;
      ext_c[1] = cand.cand_depth;
      ext_c[2] = cand.cand_stencil;
      ext_c[3] = cand.cand_accum[7:0];
      ext_c[4] = cand.cand_accum[15:8];
      ext_c[5] = cand.cand_accum[23:16];
      ext_c[6] = cand.cand_accum[31:24];
      ext_c[7] = cand.cand_samples;
   end

   always_comb begin
      color_sum = 20'd0;
      for (int k = 0; k < 3; k++) begin
         if (col_w[k] != LANE_IGNORE) color_sum = color_sum + {2'b00, sqd(col_w[k], col_c[k])};
      end
      extra_sum = 22'd0;
      for (int k = 0; k < 8; k++) begin
         if (ext_w[k] != LANE_IGNORE) extra_sum = extra_sum + {4'd0, sqd(ext_w[k], ext_c[k])};
      end
      if (cfg.want_flags[2] && !cand.cand_flags[2]) extra_sum = extra_sum + 22'd1;
   end

   assign aux_short = (cand.cand_aux < cfg.want_aux) ?
                      {1'b0, cfg.want_aux - cand.cand_aux} : 9'd0;

   always_comb begin
      score.reject  = cfg.want_flags[0] && !cand.cand_flags[0];
      score.missing = aux_short
                    + {8'd0, wanted(cfg.want_alpha)   && (cand.cand_alpha == 8'd0)}
                    + {8'd0, wanted(cfg.want_depth)   && (cand.cand_depth == 8'd0)}
                    + {8'd0, wanted(cfg.want_stencil) && (cand.cand_stencil == 8'd0)}
                    + {8'd0, wanted(cfg.want_samples) && (cand.cand_samples == 8'd0)}
                    + {8'd0, cfg.want_flags[1] != cand.cand_flags[1]};
      score.color   = (color_sum > {2'b00, COLOR_MAX}) ? COLOR_MAX : color_sum[17:0];
      score.extra   = (extra_sum > {2'b00, EXTRA_MAX}) ? EXTRA_MAX : extra_sum[19:0];
   end

endmodule

// ===== design/fbcm_select.sv =====
// Best-so-far tracker and result register of the framebuffer format selector.
module fbcm_select (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_go,
   input  logic                item_last,
   input  logic [15:0]         item_tag,
   input  fbcm_pkg::score_type score,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output fbcm_pkg::rsp_type   rsp_payload,
   output logic                out_busy
);
   import fbcm_pkg::*;

   logic        have_ff, have_in;
   logic [8:0]  missing_ff, missing_in;
   logic [17:0] color_ff, color_in;
   logic [19:0] extra_ff, extra_in;
   logic [15:0] tag_ff, tag_in;
   logic        valid_ff, valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic        better;

   assign better = !have_ff || (score.missing < missing_ff) ||
                   ((score.missing == missing_ff) &&
                    ((score.color < color_ff) ||
                     ((score.color == color_ff) && (score.extra < extra_ff))));

   always_comb begin
      have_in    = have_ff;
      missing_in = missing_ff;
      color_in   = color_ff;
      extra_in   = extra_ff;
      tag_in     = tag_ff;
      if (item_go && !score.reject && better) begin
         have_in    = 1'b1;
         missing_in = score.missing;
         color_in   = score.color;
         extra_in   = score.extra;
         tag_in     = item_tag;
      end
      valid_in = valid_ff && rsp_stall;
      rsp_in   = rsp_ff;
      if (item_go && item_last) begin
         valid_in          = 1'b1;
         rsp_in.found      = have_in;
         rsp_in.chosen_tag = have_in ? tag_in : 16'd0;
         // search ends: drop the kept candidate
         have_in    = 1'b0;
         missing_in = 9'd0;
         color_in   = 18'd0;
         extra_in   = 20'd0;
         tag_in     = 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff    <= 1'b0;
         missing_ff <= 9'd0;
         color_ff   <= 18'd0;
         extra_ff   <= 20'd0;
         tag_ff     <= 16'd0;
         valid_ff   <= 1'b0;
      end else begin
         have_ff    <= have_in;
         missing_ff <= missing_in;
         color_ff   <= color_in;
         extra_ff   <= extra_in;
         tag_ff     <= tag_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = rsp_ff;
   assign out_busy    = valid_ff && rsp_stall;

endmodule

// ===== design/framebuffer_config_best_match.sv =====
// Top level of the framebuffer format selector: config registers, input register, scoring, selection.
//
// Candidate framebuffer formats stream in on req_*, one transaction per
// cycle, and are scored against the requested format in the csr_* registers
// (write them only while no search is in flight). A candidate is registered
// on acceptance; from the input register its three scores (missing buffers,
// color distance, extra distance) are formed and compared in order against
// the kept candidate, which is replaced only by a strictly better one. The
// throughput is one candidate per cycle while req_stall is low, bounded by
// that single compare and update of the kept candidate. The candidate marked
// last yields one rsp_* transaction through the input register and then the
// result register: found and the kept tag (0 if nothing qualified), and the
// search state is cleared for the next stream. Candidates that are not last
// keep flowing while a result waits on rsp_stall; a last candidate waits in
// the input register while the result register is still held by rsp_stall,
// and req_stall is high only during that wait.
module framebuffer_config_best_match (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  fbcm_pkg::req_type                     req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output fbcm_pkg::rsp_type                     rsp_payload,
   input  logic                                  csr_write,
   input  logic [fbcm_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [fbcm_pkg::CSR_DATA_W-1:0]       csr_data
);
   import fbcm_pkg::*;

   `include "framebuffer_config_best_match_macros.svh"

   cfg_type   cfg_ff, cfg_in;
   req_type   s1_ff;
   logic      s1_valid_ff, s1_valid_in;
   logic      req_accept;
   logic      s1_go;
   logic      out_busy;
   score_type score;

   // config register file
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_COLOR:   cfg_in.want_color   = csr_data[26:0];
            CSR_ALPHA:   cfg_in.want_alpha   = csr_data[8:0];
            CSR_DEPTH:   cfg_in.want_depth   = csr_data[8:0];
            CSR_STENCIL: cfg_in.want_stencil = csr_data[8:0];
            CSR_ACCUM:   cfg_in.want_accum   = csr_data[35:0];
            CSR_AUX:     cfg_in.want_aux     = csr_data[7:0];
            CSR_SAMPLES: cfg_in.want_samples = csr_data[8:0];
            CSR_FLAGS:   cfg_in.want_flags   = csr_data[2:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input register: a last candidate holds here while the result slot is stalled
   assign s1_go       = s1_valid_ff && !(s1_ff.cand_last && out_busy);
   assign req_stall   = s1_valid_ff && !s1_go;
   assign req_accept  = req_valid && !req_stall;
   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff <= req_payload;
      end
   end

   fbcm_score u_score (
      .cfg   (cfg_ff),
      .cand  (s1_ff),
      .score (score)
   );

   fbcm_select u_select (
      .clock       (clock),
      .reset       (reset),
      .item_go     (s1_go),
      .item_last   (s1_ff.cand_last),
      .item_tag    (s1_ff.cand_tag),
      .score       (score),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .out_busy    (out_busy)
   );

   // a last candidate that goes through always produces a result next cycle
   `FBCM_ASSERT_NEXT(a_last_gives_rsp, clock, reset, s1_go && s1_ff.cand_last, rsp_valid)
   // no result tag without a found candidate
   `FBCM_ASSERT_NOW(a_tag_zero_when_none, clock, reset, rsp_valid && !rsp_payload.found,
                    rsp_payload.chosen_tag == 16'd0)
   // input stalls only for a last candidate blocked by a stalled result
   `FBCM_ASSERT_NOW(a_stall_cause, clock, reset, req_stall,
                    s1_valid_ff && s1_ff.cand_last && rsp_valid && rsp_stall)

endmodule
